>>> src/optm_pkg.sv
// shared types, command codes and arithmetic helpers for the outer product tile mac
package optm_pkg;

    localparam int TILE_DIM    = 4;
    localparam int TILE_CELLS  = TILE_DIM * TILE_DIM;
    localparam int IDX_W       = 4;
    localparam int POS_W       = 2;
    localparam int CMD_W       = 2;
    localparam int OPND_W      = 16;
    localparam int PROD_W      = 32;
    localparam int ACC_W       = 48;
    localparam int IN_DEPTH_D  = 4;
    localparam int OUT_DEPTH_D = 4;

    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd0;
    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_ACC   = 2'd2;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TILE_CELLS - 1);

    typedef logic signed [OPND_W-1:0] t_opnd;
    typedef logic signed [PROD_W-1:0] t_prod;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef logic [TILE_CELLS-1:0][PROD_W-1:0] t_prod_vec;

    // one queued request
    typedef struct packed {
        logic [CMD_W-1:0]              cmd;
        logic [TILE_DIM-1:0][OPND_W-1:0] a;
        logic [TILE_DIM-1:0][OPND_W-1:0] b;
        logic [ACC_W-1:0]              load_value;
        logic [POS_W-1:0]              load_row;
        logic [POS_W-1:0]              load_col;
    } t_item;

    // one read-out result
    typedef struct packed {
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [ACC_W-1:0] value;
        logic             last;
    } t_result;

    // control from the sequencer to the accumulator tile
    typedef struct packed {
        logic             clr;
        logic             ld;
        logic             acc;
        logic [IDX_W-1:0] ld_idx;
        logic [IDX_W-1:0] rd_idx;
    } t_tile_ctl;

    // saturating add of a q16.16 product into a q32.16 accumulator
    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] acc,
                                                 input logic [PROD_W-1:0] prod);
        logic [ACC_W:0] sum;
        sum = {acc[ACC_W-1], acc} + {{(ACC_W-PROD_W+1){prod[PROD_W-1]}}, prod};
        if (sum[ACC_W] != sum[ACC_W-1]) begin
            sat_add = sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
            sat_add = sum[ACC_W-1:0];
        end
    endfunction

endpackage

>>> src/outer_product_tile_mac.sv
// top level: 4x4 outer product accumulator tile with request and result queues
// path: a request passes the request queue and the product stage register before it
//   updates the tile; a read request then starts the read-out counter, and the results
//   reach the result ports through the result queue; clear, load and accumulate requests
//   follow back to back outside a read-out, which holds the sequencer until all sixteen
//   results are pushed into the result queue and stalls while that queue is full
// reset: synchronous active-low; empties both queues and clears all sixteen accumulators
module outer_product_tile_mac import optm_pkg::*; #(
    parameter int IN_DEPTH  = IN_DEPTH_D,
    parameter int OUT_DEPTH = OUT_DEPTH_D
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    // request side
    input  logic                     push,
    output logic                     full,
    input  logic [CMD_W-1:0]         i_cmd,
    input  logic signed [OPND_W-1:0] i_a0,
    input  logic signed [OPND_W-1:0] i_a1,
    input  logic signed [OPND_W-1:0] i_a2,
    input  logic signed [OPND_W-1:0] i_a3,
    input  logic signed [OPND_W-1:0] i_b0,
    input  logic signed [OPND_W-1:0] i_b1,
    input  logic signed [OPND_W-1:0] i_b2,
    input  logic signed [OPND_W-1:0] i_b3,
    input  logic signed [ACC_W-1:0]  i_load_value,
    input  logic [POS_W-1:0]         i_load_row,
    input  logic [POS_W-1:0]         i_load_col,
    // result side
    output logic                     empty,
    input  logic                     pop,
    output logic [POS_W-1:0]         o_out_row,
    output logic [POS_W-1:0]         o_out_col,
    output logic signed [ACC_W-1:0]  o_out_value,
    output logic                     o_out_last
);

    t_item   in_item;
    t_item   q_item;
    logic    q_empty;
    logic    q_pop;
    logic    out_full;
    logic    out_push;
    t_result out_res;
    t_result head_res;

    // pack the request fields
    always_comb begin
        in_item.cmd        = i_cmd;
        in_item.a[0]       = i_a0;
        in_item.a[1]       = i_a1;
        in_item.a[2]       = i_a2;
        in_item.a[3]       = i_a3;
        in_item.b[0]       = i_b0;
        in_item.b[1]       = i_b1;
        in_item.b[2]       = i_b2;
        in_item.b[3]       = i_b3;
        in_item.load_value = i_load_value;
        in_item.load_row   = i_load_row;
        in_item.load_col   = i_load_col;
    end

    // front: request queue decouples the feeder from the sequencer
    optm_fifo #(
        .WIDTH ($bits(t_item)),
        .DEPTH (IN_DEPTH)
    ) u_in_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (in_item),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_data  (q_item),
        .o_empty (q_empty)
    );

    // back: product stage, tile update and read-out sequencing
    optm_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (!q_empty),
        .i_item     (q_item),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_result   (out_res)
    );

    // result queue lets read-out run ahead of a slow consumer
    optm_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_res),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (head_res),
        .o_empty (empty)
    );

    // unpack the oldest result
    assign o_out_row   = head_res.row;
    assign o_out_col   = head_res.col;
    assign o_out_value = head_res.value;
    assign o_out_last  = head_res.last;

endmodule

>>> src/optm_fifo.sv
// small first-word-fall-through queue built from registers
module optm_fifo import optm_pkg::*; #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [AW:0]      r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == (AW+1)'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

>>> src/optm_tile.sv
// sixteen saturating accumulator cells with clear, load and read port
module optm_tile import optm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_tile_ctl        i_ctl,
    input  t_prod_vec        i_prod,
    input  logic [ACC_W-1:0] i_load_value,
    output logic [ACC_W-1:0] o_rd_value
);

    logic [ACC_W-1:0] r_acc [TILE_CELLS];

    for (genvar g = 0; g < TILE_CELLS; g++) begin : g_cell
        logic [ACC_W-1:0] n_acc;

        always_comb begin
            n_acc = r_acc[g];
            if (i_ctl.clr) begin
                n_acc = '0;
            end else if (i_ctl.ld && (i_ctl.ld_idx == IDX_W'(g))) begin
                n_acc = i_load_value;
            end else if (i_ctl.acc) begin
                n_acc = sat_add(r_acc[g], i_prod[g]);
            end
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_acc[g] <= '0;
            end else begin
                r_acc[g] <= n_acc;
            end
        end
    end

    assign o_rd_value = r_acc[i_ctl.rd_idx];

endmodule

>>> src/optm_back.sv
// execution side: product stage, command sequencer and read-out counter
module optm_back import optm_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_q_valid,
    input  t_item   i_item,
    output logic    o_q_pop,
    input  logic    i_out_full,
    output logic    o_out_push,
    output t_result o_result
);

    logic             r_s1_valid;
    logic [CMD_W-1:0] r_s1_cmd;
    t_prod_vec        r_s1_prod;
    logic [ACC_W-1:0] r_s1_ldv;
    logic [IDX_W-1:0] r_s1_idx;
    logic             r_busy, n_busy;
    logic [IDX_W-1:0] r_cnt,  n_cnt;
    logic             s2_take;
    logic             s1_free;
    t_prod_vec        prod;
    t_tile_ctl        tile_ctl;
    logic [ACC_W-1:0] rd_value;

    assign s2_take    = r_s1_valid && !r_busy;
    assign s1_free    = !r_s1_valid || s2_take;
    assign o_q_pop    = i_q_valid && s1_free;
    assign o_out_push = r_busy && !i_out_full;

    // cell c*4+r takes a[r]*b[c]
    always_comb begin
        for (int c = 0; c < TILE_DIM; c++) begin
            for (int r = 0; r < TILE_DIM; r++) begin
                prod[c*TILE_DIM + r] = PROD_W'($signed(i_item.a[r]) * $signed(i_item.b[c]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_cmd  <= i_item.cmd;
            r_s1_prod <= prod;
            r_s1_ldv  <= i_item.load_value;
            r_s1_idx  <= {i_item.load_col, i_item.load_row};
        end
    end

    always_comb begin
        tile_ctl.clr    = s2_take && (r_s1_cmd == CMD_CLEAR);
        tile_ctl.ld     = s2_take && (r_s1_cmd == CMD_LOAD);
        tile_ctl.acc    = s2_take && (r_s1_cmd == CMD_ACC);
        tile_ctl.ld_idx = r_s1_idx;
        tile_ctl.rd_idx = r_cnt;
    end

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        if (s2_take && (r_s1_cmd == CMD_READ)) begin
            n_busy = 1'b1;
            n_cnt  = '0;
        end else if (o_out_push) begin
            n_cnt = r_cnt + 1'b1;
            if (r_cnt == LAST_IDX) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
    end

    optm_tile u_tile (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (tile_ctl),
        .i_prod       (r_s1_prod),
        .i_load_value (r_s1_ldv),
        .o_rd_value   (rd_value)
    );

    // column-major order: low bits row, high bits column
    assign o_result.row   = r_cnt[POS_W-1:0];
    assign o_result.col   = r_cnt[IDX_W-1:POS_W];
    assign o_result.value = rd_value;
    assign o_result.last  = (r_cnt == LAST_IDX);

    a_push_only_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> r_busy)
        else $error("result pushed outside read-out");

    a_start_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s2_take && (r_s1_cmd == CMD_READ)) |=> (r_busy && (r_cnt == '0)))
        else $error("read-out did not start at first element");

    a_end_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_push && (r_cnt == LAST_IDX)) |=> !r_busy)
        else $error("read-out did not end after last element");

    a_no_exec_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> !(tile_ctl.clr || tile_ctl.ld || tile_ctl.acc))
        else $error("tile changed during read-out");

endmodule

>>> test/tb_outer_product_tile_mac.sv
// self-checking testbench for the outer product tile mac: directed and random request streams
module tb_outer_product_tile_mac import optm_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    // saturation bounds of a q32.16 accumulator
    localparam t_acc ACC_HI = {1'b0, {(ACC_W-1){1'b1}}};
    localparam t_acc ACC_LO = {1'b1, {(ACC_W-1){1'b0}}};
    localparam int SETTLE_CYCLES = 24;

    logic                     i_clk = 1'b0;
    logic                     i_rst_n = 1'b0;
    logic                     push = 1'b0;
    logic                     full;
    logic [CMD_W-1:0]         i_cmd = '0;
    logic signed [OPND_W-1:0] i_a0 = '0;
    logic signed [OPND_W-1:0] i_a1 = '0;
    logic signed [OPND_W-1:0] i_a2 = '0;
    logic signed [OPND_W-1:0] i_a3 = '0;
    logic signed [OPND_W-1:0] i_b0 = '0;
    logic signed [OPND_W-1:0] i_b1 = '0;
    logic signed [OPND_W-1:0] i_b2 = '0;
    logic signed [OPND_W-1:0] i_b3 = '0;
    logic signed [ACC_W-1:0]  i_load_value = '0;
    logic [POS_W-1:0]         i_load_row = '0;
    logic [POS_W-1:0]         i_load_col = '0;
    logic                     empty;
    logic                     pop = 1'b0;
    logic [POS_W-1:0]         o_out_row;
    logic [POS_W-1:0]         o_out_col;
    logic signed [ACC_W-1:0]  o_out_value;
    logic                     o_out_last;

    outer_product_tile_mac dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .push         (push),
        .full         (full),
        .i_cmd        (i_cmd),
        .i_a0         (i_a0),
        .i_a1         (i_a1),
        .i_a2         (i_a2),
        .i_a3         (i_a3),
        .i_b0         (i_b0),
        .i_b1         (i_b1),
        .i_b2         (i_b2),
        .i_b3         (i_b3),
        .i_load_value (i_load_value),
        .i_load_row   (i_load_row),
        .i_load_col   (i_load_col),
        .empty        (empty),
        .pop          (pop),
        .o_out_row    (o_out_row),
        .o_out_col    (o_out_col),
        .o_out_value  (o_out_value),
        .o_out_last   (o_out_last)
    );

    // pending requests, the shadow tile and the read-out values it predicts
    t_item   request_q[$];
    t_acc    shadow_tile[TILE_CELLS];
    t_result readout_q[$];

    int mismatch_cnt = 0;
    int results_seen = 0;
    int req_count[4] = '{0, 0, 0, 0};

    // driver pacing
    t_item drv_item;
    int    burst_left = 1;
    int    gap_left = 0;

    // receiver stall pattern
    int rx_cycle = 0;
    int rx_mode = 0;
    int stall_left = 0;

    // clock and reset
    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    task automatic note_mismatch(input string msg);
        mismatch_cnt++;
        $display("%0t mismatch: %s", $realtime, msg);
    endtask

    // one accumulator step: exact q16.16 product added with saturation
    function automatic t_acc mac_saturate(input t_acc acc, input t_opnd x, input t_opnd y);
        longint sum;
        sum = longint'(acc) + longint'(x) * longint'(y);
        if (sum > longint'(ACC_HI)) begin
            return ACC_HI;
        end else if (sum < longint'(ACC_LO)) begin
            return ACC_LO;
        end
        return t_acc'(sum);
    endfunction

    // advance the shadow tile by one accepted request; a read-out queues sixteen values
    function automatic void update_shadow_tile(input t_item rq);
        t_result res;
        int      idx;
        case (rq.cmd)
            CMD_CLEAR: begin
                foreach (shadow_tile[i]) shadow_tile[i] = '0;
            end
            CMD_LOAD: begin
                shadow_tile[rq.load_col * TILE_DIM + rq.load_row] = rq.load_value;
            end
            CMD_ACC: begin
                for (int c = 0; c < TILE_DIM; c++) begin
                    for (int r = 0; r < TILE_DIM; r++) begin
                        idx = c * TILE_DIM + r;
                        shadow_tile[idx] = mac_saturate(shadow_tile[idx], rq.a[r], rq.b[c]);
                    end
                end
            end
            CMD_READ: begin
                // column-major, row by row inside a column
                for (int c = 0; c < TILE_DIM; c++) begin
                    for (int r = 0; r < TILE_DIM; r++) begin
                        res.row   = POS_W'(r);
                        res.col   = POS_W'(c);
                        res.value = shadow_tile[c * TILE_DIM + r];
                        res.last  = (c == TILE_DIM - 1) && (r == TILE_DIM - 1);
                        readout_q.push_back(res);
                    end
                end
            end
        endcase
    endfunction

    // operands lean on the extremes often enough to hit saturation
    function automatic t_opnd rand_opnd();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return t_opnd'(int'($urandom_range(0, 511)) - 256);
            default: return t_opnd'($urandom);
        endcase
    endfunction

    function automatic t_acc rand_acc();
        case ($urandom_range(0, 5))
            0: return ACC_HI - t_acc'($urandom_range(0, 1 << 31));
            1: return ACC_LO + t_acc'($urandom_range(0, 1 << 31));
            2: return t_acc'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
            default: return t_acc'({$urandom, $urandom});
        endcase
    endfunction

    // fields the command does not use are filled with noise on purpose
    function automatic t_item make_req(input logic [CMD_W-1:0] cmd);
        t_item rq;
        rq.cmd = cmd;
        for (int i = 0; i < TILE_DIM; i++) begin
            rq.a[i] = rand_opnd();
            rq.b[i] = rand_opnd();
        end
        rq.load_value = rand_acc();
        rq.load_row   = POS_W'($urandom);
        rq.load_col   = POS_W'($urandom);
        return rq;
    endfunction

    function automatic t_item load_req(input int r, input int c, input t_acc v);
        t_item rq;
        rq = make_req(CMD_LOAD);
        rq.load_row   = POS_W'(r);
        rq.load_col   = POS_W'(c);
        rq.load_value = v;
        return rq;
    endfunction

    function automatic t_item acc_req(input t_opnd av, input t_opnd bv);
        t_item rq;
        rq = make_req(CMD_ACC);
        for (int i = 0; i < TILE_DIM; i++) begin
            rq.a[i] = av;
            rq.b[i] = bv;
        end
        return rq;
    endfunction

    // driver: takes requests from request_q in bursts, holds each one until accepted
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                update_shadow_tile(drv_item);
                req_count[drv_item.cmd]++;
            end
            // slot is free once nothing is held or the held request just went in
            if (!push || !full) begin
                if (gap_left > 0) begin
                    gap_left--;
                    push <= 1'b0;
                end else if (request_q.size() != 0) begin
                    drv_item = request_q.pop_front();
                    push         <= 1'b1;
                    i_cmd        <= drv_item.cmd;
                    i_a0         <= drv_item.a[0];
                    i_a1         <= drv_item.a[1];
                    i_a2         <= drv_item.a[2];
                    i_a3         <= drv_item.a[3];
                    i_b0         <= drv_item.b[0];
                    i_b1         <= drv_item.b[1];
                    i_b2         <= drv_item.b[2];
                    i_b3         <= drv_item.b[3];
                    i_load_value <= drv_item.load_value;
                    i_load_row   <= drv_item.load_row;
                    i_load_col   <= drv_item.load_col;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else if ($urandom_range(0, 2) == 0) begin
                        // long back-to-back stretch
                        burst_left = $urandom_range(40, 80);
                        gap_left   = 0;
                    end else begin
                        burst_left = $urandom_range(1, 8);
                        gap_left   = $urandom_range(1, 6);
                    end
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every popped result against the oldest predicted one
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                results_seen++;
                if (readout_q.size() == 0) begin
                    note_mismatch($sformatf("result (%0d,%0d) with none predicted",
                                            o_out_row, o_out_col));
                end else begin
                    t_result want;
                    want = readout_q.pop_front();
                    if (o_out_row !== want.row) begin
                        note_mismatch($sformatf("row got %0d want %0d", o_out_row, want.row));
                    end
                    if (o_out_col !== want.col) begin
                        note_mismatch($sformatf("col got %0d want %0d", o_out_col, want.col));
                    end
                    if (o_out_value !== want.value) begin
                        note_mismatch($sformatf("value at (%0d,%0d) got %0d want %0d",
                                                want.row, want.col, o_out_value,
                                                $signed(want.value)));
                    end
                    if (o_out_last !== want.last) begin
                        note_mismatch($sformatf("last at (%0d,%0d) got %0b want %0b",
                                                want.row, want.col, o_out_last, want.last));
                    end
                end
            end
            // stall pattern changes character, drawn at random from three modes
            if (rx_cycle % 128 == 0) begin
                rx_mode = $urandom_range(0, 2);
            end
            rx_cycle++;
            case (rx_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                default: begin
                    if (stall_left > 0) begin
                        stall_left--;
                        pop <= 1'b0;
                    end else begin
                        pop <= 1'b1;
                        if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 8);
                    end
                end
            endcase
        end
    end

    // stimulus and end of run
    initial begin
        int    directed_n;
        int    steps;
        t_item rq;

        // read-out straight after reset sees an all-zero tile
        request_q.push_back(make_req(CMD_READ));
        // park cells next to both rails, then push them over
        request_q.push_back(load_req(0, 0, ACC_HI - 5));
        request_q.push_back(load_req(3, 3, ACC_LO + 5));
        request_q.push_back(load_req(2, 1, ACC_HI));
        request_q.push_back(load_req(1, 2, ACC_LO));
        request_q.push_back(acc_req(16'sh8000, 16'sh7FFF));
        request_q.push_back(acc_req(16'sh8000, 16'sh8000));
        request_q.push_back(make_req(CMD_READ));
        request_q.push_back(make_req(CMD_CLEAR));
        request_q.push_back(make_req(CMD_READ));
        request_q.push_back(load_req(3, 0, ACC_HI));
        request_q.push_back(load_req(0, 3, ACC_LO));
        request_q.push_back(acc_req(16'sh7FFF, 16'sh7FFF));
        // mixed signs across rows and columns
        rq = acc_req(16'sh0000, 16'sh0000);
        rq.a[0] = 16'sh8000; rq.a[1] = 16'sh7FFF; rq.a[3] = 16'sh0001;
        rq.b[0] = 16'sh7FFF; rq.b[1] = 16'sh8000; rq.b[2] = 16'shFFFF;
        request_q.push_back(rq);
        request_q.push_back(acc_req(16'sh0000, 16'sh0000));
        request_q.push_back(make_req(CMD_READ));
        directed_n = request_q.size();

        // random part: optional clear/load, k accumulates, a read-out, or a lone request
        while (request_q.size() < directed_n + 250) begin
            if ($urandom_range(0, 99) < 15) begin
                request_q.push_back(make_req(CMD_W'($urandom_range(0, 3))));
            end else begin
                case ($urandom_range(0, 3))
                    0: request_q.push_back(make_req(CMD_CLEAR));
                    1: begin
                        request_q.push_back(make_req(CMD_CLEAR));
                        repeat ($urandom_range(1, 4)) request_q.push_back(make_req(CMD_LOAD));
                    end
                    2: repeat ($urandom_range(1, 4)) request_q.push_back(make_req(CMD_LOAD));
                    default: ;
                endcase
                steps = $urandom_range(1, 8);
                repeat (steps) begin
                    if ($urandom_range(0, 9) == 0) request_q.push_back(make_req(CMD_LOAD));
                    request_q.push_back(make_req(CMD_ACC));
                end
                request_q.push_back(make_req(CMD_READ));
            end
        end

        // drain: everything accepted, every predicted result popped, then settle
        while (request_q.size() != 0 || push) @(posedge i_clk);
        while (readout_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("requests: %0d clear, %0d load, %0d accumulate, %0d read-out",
                 req_count[CMD_CLEAR], req_count[CMD_LOAD], req_count[CMD_ACC],
                 req_count[CMD_READ]);
        $display("tile values checked: %0d, mismatches: %0d", results_seen, mismatch_cnt);
        if (mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #5_000_000;
        $display("timeout with %0d values still predicted", readout_q.size());
        $display("status: fail");
        $finish;
    end

endmodule

>>> files.f
src/optm_pkg.sv
src/optm_fifo.sv
src/optm_tile.sv
src/optm_back.sv
src/outer_product_tile_mac.sv
test/tb_outer_product_tile_mac.sv
